/* hw/rtl/knc_pkg.sv */
// Shared types, constants and codes of the k-nearest candidate list.
package knc_pkg;

  // Fixed field widths of the item and result beats
  localparam int unsigned QID_W     = 16;
  localparam int unsigned CID_W     = 16;
  localparam int unsigned CDIST_W   = 32;
  localparam int unsigned RANK_W    = 6;
  localparam int unsigned K_W       = 7;
  localparam logic [K_W-1:0] K_RESET = 7'd8;

  // Defaults of the top level parameters
  localparam int unsigned MAX_NEIGHBOURS_DEF = 64;
  localparam int unsigned ID_WIDTH_DEF       = 16;
  localparam int unsigned DIST_WIDTH_DEF     = 32;

  // Input beat
  typedef struct packed {
    logic               new_query;
    logic [QID_W-1:0]   query_id;
    logic               has_candidate;
    logic [CID_W-1:0]   candidate_id;
    logic [CDIST_W-1:0] candidate_sq_distance;
    logic               finish;
  } item_t;

  // Result beat
  typedef struct packed {
    logic [QID_W-1:0]   out_query_id;
    logic [RANK_W-1:0]  rank;
    logic [CID_W-1:0]   neighbour_id;
    logic [CDIST_W-1:0] neighbour_sq_distance;
    logic [CDIST_W-1:0] search_radius;
    logic               list_empty;
    logic               last_entry;
  } result_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // take the accepted item: clear and/or insert
    logic rotate;  // rotate the cell row one place toward cell 0
  } cmd_t;

  // Readout control from controller
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              empty;
    logic [RANK_W-1:0] rank;
  } rd_ctl_t;

endpackage

/* hw/rtl/k_nearest_candidate_list.sv */
// Top level of the k-nearest candidate list: controller, datapath and result beat.
//
//  channel  | ports                               | handshake
//  ---------+-------------------------------------+--------------------------------
//  item     | start, busy, item_i                 | taken on start && !busy
//  result   | result_valid_o, result_o            | valid per beat, no stall
//  config   | cfg_we_i, cfg_wdata_i               | written on cfg_we_i
//
//  An item without finish needs no readout: the compare-and-shift cell row inserts
//  in the edge that accepts it. An item with finish holds busy while the row
//  rotates once through its head cell; the held entries come out in rank order
//  at the end of that rotation (a single beat on an empty list, which does not rotate).
//  Reset clears count, radius and query and sets K to 8; the cells are not cleared.
//  The receiver cannot stall; each beat is valid for exactly one cycle.
module k_nearest_candidate_list #(
  parameter int unsigned MAX_NEIGHBOURS = knc_pkg::MAX_NEIGHBOURS_DEF,
  parameter int unsigned ID_WIDTH       = knc_pkg::ID_WIDTH_DEF,
  parameter int unsigned DIST_WIDTH     = knc_pkg::DIST_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  knc_pkg::item_t           item_i,
  output logic                     result_valid_o,
  output knc_pkg::result_t         result_o,
  input  logic                     cfg_we_i,
  input  logic [knc_pkg::K_W-1:0]  cfg_wdata_i
);
  import knc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_NEIGHBOURS + 1);

  cmd_t                  cmd;
  rd_ctl_t               rd;
  logic [CW-1:0]         cnt;
  logic [ID_WIDTH-1:0]   head_id;
  logic [DIST_WIDTH-1:0] head_dist;
  logic [DIST_WIDTH-1:0] radius;
  logic [QID_W-1:0]      query;

  knc_ctrl #(
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .finish_i (item_i.finish),
    .cnt_i    (cnt),
    .busy_o   (busy),
    .cmd_o    (cmd),
    .rd_o     (rd)
  );

  knc_datapath #(
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
    .ID_WIDTH       (ID_WIDTH),
    .DIST_WIDTH     (DIST_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cnt_o       (cnt),
    .head_id_o   (head_id),
    .head_dist_o (head_dist),
    .radius_o    (radius),
    .query_o     (query)
  );

  // Assemble the result beat; an empty list reads as zero fields but for list_empty and last_entry
  always_comb begin
    result_valid_o = rd.valid;
    result_o       = '0;
    result_o.list_empty = rd.empty;
    result_o.last_entry = rd.last;
    if (!rd.empty) begin
      result_o.out_query_id          = query;
      result_o.rank                  = rd.rank;
      result_o.neighbour_id          = CID_W'(head_id);
      result_o.neighbour_sq_distance = CDIST_W'(head_dist);
      result_o.search_radius         = CDIST_W'(radius);
    end
  end

endmodule

/* hw/rtl/knc_ctrl.sv */
// Controller state machine: item acceptance and readout sequencing.
module knc_ctrl #(
  parameter int unsigned MAX_NEIGHBOURS = knc_pkg::MAX_NEIGHBOURS_DEF,
  localparam int unsigned CW = $clog2(MAX_NEIGHBOURS + 1),
  localparam int unsigned JW = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 finish_i,
  input  logic [CW-1:0]        cnt_i,
  output logic                 busy_o,
  output knc_pkg::cmd_t        cmd_o,
  output knc_pkg::rd_ctl_t     rd_o
);
  import knc_pkg::*;

  state_e        state_q, state_d;
  logic [JW-1:0] step_q, step_d;
  logic [CW:0]   pos_sum;

  // State and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Step plus held count: the row head holds rank (sum - MAX) once sum reaches MAX
  assign pos_sum = (CW+1)'(step_q) + (CW+1)'(cnt_i);

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    cmd_o        = '0;
    rd_o         = '0;
    busy_o       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          if (finish_i) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        busy_o = 1'b1;
        if (cnt_i == '0) begin
          // Empty list: one beat, then done
          rd_o.valid = 1'b1;
          rd_o.last  = 1'b1;
          rd_o.empty = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          // Full rotation restores the row; the held ranks pass the head last
          cmd_o.rotate = 1'b1;
          if (pos_sum >= (CW+1)'(MAX_NEIGHBOURS)) begin
            rd_o.valid = 1'b1;
            rd_o.rank  = RANK_W'(pos_sum - (CW+1)'(MAX_NEIGHBOURS));
          end
          if (step_q == JW'(MAX_NEIGHBOURS - 1)) begin
            rd_o.last = 1'b1;
            step_d    = '0;
            state_d   = ST_IDLE;
          end else begin
            step_d = step_q + JW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Beats only come out of a readout
  a_beat_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_o.valid |-> state_q == ST_READ)
    else $error("result beat outside readout");

  // Final beat ends the readout
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_o.valid && rd_o.last |=> state_q == ST_IDLE)
    else $error("readout continues after final beat");

  // Ranks follow one another without gaps
  a_rank_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_o.valid && !rd_o.last |=> rd_o.valid && rd_o.rank == RANK_W'($past(rd_o.rank) + 1'b1))
    else $error("rank sequence broken");

  // Row never loads and rotates together
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.rotate))
    else $error("load and rotate at once");

endmodule

/* hw/rtl/knc_datapath.sv */
// Datapath: compare-and-shift cell row, count, radius, query and K register.
module knc_datapath #(
  parameter int unsigned MAX_NEIGHBOURS = knc_pkg::MAX_NEIGHBOURS_DEF,
  parameter int unsigned ID_WIDTH       = knc_pkg::ID_WIDTH_DEF,
  parameter int unsigned DIST_WIDTH     = knc_pkg::DIST_WIDTH_DEF,
  localparam int unsigned CW = $clog2(MAX_NEIGHBOURS + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  knc_pkg::cmd_t                cmd_i,
  input  knc_pkg::item_t               item_i,
  input  logic                         cfg_we_i,
  input  logic [knc_pkg::K_W-1:0]      cfg_wdata_i,
  output logic [CW-1:0]                cnt_o,
  output logic [ID_WIDTH-1:0]          head_id_o,
  output logic [DIST_WIDTH-1:0]        head_dist_o,
  output logic [DIST_WIDTH-1:0]        radius_o,
  output logic [knc_pkg::QID_W-1:0]    query_o
);
  import knc_pkg::*;

  localparam int unsigned M = MAX_NEIGHBOURS;

  // Cell row, right aligned: rank 0 sits at cell M-count, the farthest at cell M-1
  logic [ID_WIDTH-1:0]   id_q   [M];
  logic [ID_WIDTH-1:0]   id_d   [M];
  logic [DIST_WIDTH-1:0] dist_q [M];
  logic [DIST_WIDTH-1:0] dist_d [M];

  logic [CW-1:0]         cnt_q, cnt_d;
  logic [DIST_WIDTH-1:0] radius_q, radius_d;
  logic [QID_W-1:0]      query_q, query_d;
  logic [K_W-1:0]        k_q;

  logic [CW-1:0]         cnt_eff;
  logic [CW-1:0]         lim;
  logic                  full;
  logic                  take;
  logic [ID_WIDTH-1:0]   cand_id;
  logic [DIST_WIDTH-1:0] cand_dist;
  logic [M-1:0]          in_list;
  logic [M-1:0]          le;
  logic [M-1:0]          lt;
  logic [M-1:0]          grow_edge;
  logic [M-1:0]          head_cell;
  logic                  le_up;
  logic                  lt_dn;

  // Clamp K into 1..MAX
  always_comb begin
    if (k_q == '0) begin
      lim = CW'(1);
    end else if (k_q > K_W'(M)) begin
      lim = CW'(M);
    end else begin
      lim = CW'(k_q);
    end
  end

  assign cnt_eff   = item_i.new_query ? '0 : cnt_q;
  assign cand_id   = ID_WIDTH'(item_i.candidate_id);
  assign cand_dist = DIST_WIDTH'(item_i.candidate_sq_distance);
  assign full      = (cnt_eff >= lim);
  assign take      = item_i.has_candidate &&
                     (!full || (cnt_eff != '0 && cand_dist < radius_q));

  // Per-cell compares against the candidate
  always_comb begin
    for (int i = 0; i < M; i++) begin
      in_list[i]   = (cnt_eff >= CW'(M - i));
      grow_edge[i] = (cnt_eff == CW'(M - 1 - i));
      head_cell[i] = (cnt_eff == CW'(M - i));
      le[i]        = in_list[i] && (dist_q[i] <= cand_dist);
      lt[i]        = in_list[i] && (dist_q[i] <  cand_dist);
    end
  end

  // Next value of each cell: rotate, insert into a growing list, or replace the last
  always_comb begin
    le_up = 1'b0;
    lt_dn = 1'b0;
    for (int i = 0; i < M; i++) begin
      id_d[i]   = id_q[i];
      dist_d[i] = dist_q[i];
      le_up     = (i < M - 1) && le[(i + 1) % M];
      lt_dn     = (i > 0) && lt[(i + M - 1) % M];
      if (cmd_i.rotate) begin
        id_d[i]   = id_q[(i + 1) % M];
        dist_d[i] = dist_q[(i + 1) % M];
      end else if (cmd_i.load && take) begin
        if (!full) begin
          // Growing: entries not farther than the candidate move one place down
          if (in_list[i] || grow_edge[i]) begin
            if (le_up) begin
              id_d[i]   = id_q[(i + 1) % M];
              dist_d[i] = dist_q[(i + 1) % M];
            end else if (le[i] || grow_edge[i]) begin
              id_d[i]   = cand_id;
              dist_d[i] = cand_dist;
            end
          end
        end else if (in_list[i] && !lt[i]) begin
          // Full: entries not closer move one place up, the farthest drops off
          if (head_cell[i] || lt_dn) begin
            id_d[i]   = cand_id;
            dist_d[i] = cand_dist;
          end else begin
            id_d[i]   = id_q[(i + M - 1) % M];
            dist_d[i] = dist_q[(i + M - 1) % M];
          end
        end
      end
    end
  end

  // Count, radius and query on an accepted item
  always_comb begin
    cnt_d    = cnt_q;
    radius_d = radius_q;
    query_d  = query_q;
    if (cmd_i.load) begin
      cnt_d = cnt_eff;
      if (item_i.new_query) begin
        radius_d = '0;
        query_d  = item_i.query_id;
      end
      if (take) begin
        radius_d = dist_d[M-1];
        if (!full) begin
          cnt_d = cnt_eff + CW'(1);
        end
      end
    end
  end

  // Cell row payload
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < M; i++) begin
      id_q[i]   <= id_d[i];
      dist_q[i] <= dist_d[i];
    end
  end

  // Control and register state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      radius_q <= '0;
      query_q  <= '0;
      k_q      <= K_RESET;
    end else begin
      cnt_q    <= cnt_d;
      radius_q <= radius_d;
      query_q  <= query_d;
      if (cfg_we_i) begin
        k_q <= cfg_wdata_i;
      end
    end
  end

  assign cnt_o       = cnt_q;
  assign head_id_o   = id_q[0];
  assign head_dist_o = dist_q[0];
  assign radius_o    = radius_q;
  assign query_o     = query_q;

  // Count stays within the row
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(M))
    else $error("entry count beyond row length");

  // Count changes only on an accepted item
  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cmd_i.load) |-> $stable(cnt_q))
    else $error("entry count moved without an item");

  // Empty list keeps a zero radius
  a_radius_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> radius_q == '0)
    else $error("nonzero radius on an empty list");

endmodule
